// ----- rtl/csip_pkg.sv -----
// ----------------------------------------------------------------------------
// csip_pkg
// Shared types and constants for the compiled-script image parser.
// ----------------------------------------------------------------------------
package csip_pkg;

	// Section steps of the image sequencer.
	localparam logic [3:0] ST_VERSION = 4'd0;
	localparam logic [3:0] ST_GSIZE   = 4'd1;
	localparam logic [3:0] ST_GBYTES  = 4'd2;
	localparam logic [3:0] ST_GFCOUNT = 4'd3;
	localparam logic [3:0] ST_GFLOATS = 4'd4;
	localparam logic [3:0] ST_FSIZE   = 4'd5;
	localparam logic [3:0] ST_FBYTES  = 4'd6;
	localparam logic [3:0] ST_FFCOUNT = 4'd7;
	localparam logic [3:0] ST_FFLOATS = 4'd8;
	localparam logic [3:0] ST_CSIZE   = 4'd9;
	localparam logic [3:0] ST_LBCOUNT = 4'd10;
	localparam logic [3:0] ST_CODE    = 4'd11;
	localparam logic [3:0] ST_LINES   = 4'd12;
	localparam logic [3:0] ST_ICOUNT  = 4'd13;
	localparam logic [3:0] ST_IDENT   = 4'd14;
	localparam logic [3:0] ST_DONE    = 4'd15;

	// Record kinds.
	localparam logic [3:0] RK_VERSION = 4'd0;
	localparam logic [3:0] RK_SIZE    = 4'd1;
	localparam logic [3:0] RK_GSTR    = 4'd2;
	localparam logic [3:0] RK_GFLOAT  = 4'd3;
	localparam logic [3:0] RK_FSTR    = 4'd4;
	localparam logic [3:0] RK_FFLOAT  = 4'd5;
	localparam logic [3:0] RK_CODE    = 4'd6;
	localparam logic [3:0] RK_LINE    = 4'd7;
	localparam logic [3:0] RK_IDENT   = 4'd8;
	localparam logic [3:0] RK_DONE    = 4'd9;

	// Parse status codes.
	localparam logic [1:0] PS_OK        = 2'd0;
	localparam logic [1:0] PS_TRUNCATED = 2'd1;
	localparam logic [1:0] PS_EARLY     = 2'd2;

	localparam logic [7:0] EXT_MARK = 8'hFF;

	// One output record.
	typedef struct packed {
		logic [3:0]  kind;
		logic [63:0] value;
		logic [31:0] aux;
		logic        ext;
		logic [1:0]  status;
		logic        last;
	} rec_t;

	// Everything one input item produces, at most two records.
	typedef struct packed {
		logic [1:0] cnt;
		rec_t       r0;
		rec_t       r1;
	} bundle_t;

endpackage

// ----- rtl/csip_front.sv -----
// ----------------------------------------------------------------------------
// csip_front
// Section sequencer: takes one byte per cycle while not stalled and builds its records.
// ----------------------------------------------------------------------------
module csip_front import csip_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       end_of_data,
	output bundle_t    bundle
);

	logic [3:0]  step_q;
	logic [2:0]  fcnt_q;
	logic [63:0] shift_q;
	logic [31:0] left_q;
	logic [31:0] idx_q;
	logic [31:0] pos_q;
	logic [31:0] sidx_q;
	logic [31:0] line_q;
	logic [1:0]  phase_q;
	logic        ext_q;

	logic [3:0]  step_d;
	logic [2:0]  fcnt_d;
	logic [63:0] shift_d;
	logic [31:0] left_d;
	logic [31:0] idx_d;
	logic [31:0] pos_d;
	logic [31:0] sidx_d;
	logic [31:0] line_d;
	logic [1:0]  phase_d;
	logic        ext_d;

	logic [63:0] word;
	logic [2:0]  fcnt_inc;
	logic        done4;
	logic        done8;
	logic [31:0] w32;
	rec_t        rec;
	logic        have;
	bundle_t     b;
	logic [1:0]  status;

	// Word assembly: the byte lands in the lane chosen by the byte count.
	always_comb begin
		word = shift_q | ({56'd0, data_byte} << {fcnt_q, 3'b000});
		fcnt_inc = fcnt_q + 3'd1;
		done4 = (fcnt_inc == 3'd4);
		done8 = (fcnt_inc == 3'd0);
		w32 = word[31:0];
	end

	// Step logic.
	always_comb begin
		step_d = step_q;
		fcnt_d = fcnt_q;
		shift_d = shift_q;
		left_d = left_q;
		idx_d = idx_q;
		pos_d = pos_q;
		sidx_d = sidx_q;
		line_d = line_q;
		phase_d = phase_q;
		ext_d = ext_q;
		have = 1'b0;
		rec = '0;
		b = '0;
		status = PS_EARLY;

		case (step_q)
			ST_VERSION, ST_GSIZE, ST_GFCOUNT, ST_FSIZE, ST_FFCOUNT, ST_CSIZE,
			ST_LBCOUNT, ST_LINES, ST_ICOUNT, ST_IDENT: begin
				if (done4) begin
					fcnt_d = 3'd0;
					shift_d = '0;
				end else begin
					fcnt_d = fcnt_inc;
					shift_d = word;
				end
			end
			ST_GFLOATS, ST_FFLOATS: begin
				fcnt_d = fcnt_inc;
				shift_d = done8 ? 64'd0 : word;
			end
			default: ;
		endcase

		case (step_q)
			ST_VERSION: begin
				if (done4) begin
					have = 1'b1;
					rec.kind = RK_VERSION;
					rec.value = {32'd0, w32};
					step_d = ST_GSIZE;
				end
			end
			ST_GSIZE, ST_FSIZE, ST_GFCOUNT, ST_FFCOUNT: begin
				if (done4) begin
					have = 1'b1;
					rec.kind = RK_SIZE;
					rec.value = {32'd0, w32};
					rec.aux = {28'd0, step_q};
					left_d = w32;
					idx_d = '0;
					step_d = step_q + ((w32 != 0) ? 4'd1 : 4'd2);
				end
			end
			ST_GBYTES, ST_FBYTES: begin
				have = 1'b1;
				rec.kind = (step_q == ST_GBYTES) ? RK_GSTR : RK_FSTR;
				rec.value = {56'd0, data_byte};
				rec.aux = idx_q;
				idx_d = idx_q + 32'd1;
				left_d = left_q - 32'd1;
				if (left_q == 32'd1) step_d = step_q + 4'd1;
			end
			ST_GFLOATS, ST_FFLOATS: begin
				if (done8) begin
					have = 1'b1;
					rec.kind = (step_q == ST_GFLOATS) ? RK_GFLOAT : RK_FFLOAT;
					rec.value = word;
					rec.aux = idx_q;
					idx_d = idx_q + 32'd1;
					left_d = left_q - 32'd1;
					if (left_q == 32'd1) step_d = step_q + 4'd1;
				end
			end
			ST_CSIZE: begin
				if (done4) begin
					have = 1'b1;
					rec.kind = RK_SIZE;
					rec.value = {32'd0, w32};
					rec.aux = {28'd0, ST_CSIZE};
					left_d = w32;
					step_d = ST_LBCOUNT;
				end
			end
			ST_LBCOUNT: begin
				if (done4) begin
					have = 1'b1;
					rec.kind = RK_SIZE;
					rec.value = {32'd0, w32};
					rec.aux = {28'd0, ST_LBCOUNT};
					pos_d = w32;
					idx_d = '0;
					ext_d = 1'b0;
					if (left_q != 0) step_d = ST_CODE;
					else begin
						step_d = (w32 != 0) ? ST_LINES : ST_ICOUNT;
						phase_d = 2'd0;
					end
				end
			end
			ST_CODE: begin
				if (!ext_q && data_byte == EXT_MARK) begin
					ext_d = 1'b1;
					shift_d = '0;
					fcnt_d = 3'd0;
				end else if (!ext_q || done4) begin
					if (ext_q) begin
						fcnt_d = 3'd0;
						shift_d = '0;
					end
					have = 1'b1;
					rec.kind = RK_CODE;
					rec.value = ext_q ? {32'd0, w32} : {56'd0, data_byte};
					rec.aux = idx_q;
					rec.ext = ext_q;
					ext_d = 1'b0;
					idx_d = idx_q + 32'd1;
					left_d = left_q - 32'd1;
					if (left_q == 32'd1) begin
						step_d = (pos_q != 0) ? ST_LINES : ST_ICOUNT;
						phase_d = 2'd0;
					end
				end else begin
					fcnt_d = fcnt_inc;
					shift_d = word;
				end
			end
			ST_LINES: begin
				if (done4) begin
					if (phase_q == 2'd0) begin
						line_d = w32;
						phase_d = 2'd1;
					end else begin
						have = 1'b1;
						rec.kind = RK_LINE;
						rec.value = {32'd0, line_q};
						rec.aux = w32;
						phase_d = 2'd0;
						pos_d = pos_q - 32'd1;
						if (pos_q == 32'd1) step_d = ST_ICOUNT;
					end
				end
			end
			ST_ICOUNT: begin
				if (done4) begin
					have = 1'b1;
					rec.kind = RK_SIZE;
					rec.value = {32'd0, w32};
					rec.aux = {28'd0, ST_ICOUNT};
					left_d = w32;
					phase_d = 2'd0;
					step_d = (w32 != 0) ? ST_IDENT : ST_DONE;
				end
			end
			ST_IDENT: begin
				if (done4) begin
					if (phase_q == 2'd0) begin
						sidx_d = w32;
						phase_d = 2'd1;
					end else if (phase_q == 2'd1) begin
						pos_d = w32;
						if (w32 != 0) phase_d = 2'd2;
						else begin
							left_d = left_q - 32'd1;
							phase_d = 2'd0;
							if (left_q == 32'd1) step_d = ST_DONE;
						end
					end else begin
						have = 1'b1;
						rec.kind = RK_IDENT;
						rec.value = {32'd0, w32};
						rec.aux = sidx_q;
						pos_d = pos_q - 32'd1;
						if (pos_q == 32'd1) begin
							left_d = left_q - 32'd1;
							phase_d = 2'd0;
							if (left_q == 32'd1) step_d = ST_DONE;
						end
					end
				end
			end
			default: ;
		endcase

		// End of data: the byte's own record or a cut-short opcode, if any, then the done record.
		if (end_of_data) begin
			if (step_d == ST_DONE) status = PS_OK;
			else if (step_d == ST_GBYTES || step_d == ST_FBYTES) status = PS_TRUNCATED;
			else status = PS_EARLY;
			if (step_d == ST_CODE && ext_d && !have) begin
				have = 1'b1;
				rec = '0;
				rec.kind = RK_CODE;
				rec.aux = idx_d;
				rec.ext = 1'b1;
			end
			b.r0 = rec;
			b.r1 = '0;
			b.r1.kind = RK_DONE;
			b.r1.status = status;
			b.r1.last = 1'b1;
			if (have) begin
				b.cnt = 2'd2;
			end else begin
				b.cnt = 2'd1;
				b.r0 = b.r1;
			end
			step_d = ST_VERSION;
			fcnt_d = '0;
			shift_d = '0;
			left_d = '0;
			idx_d = '0;
			pos_d = '0;
			sidx_d = '0;
			line_d = '0;
			phase_d = '0;
			ext_d = 1'b0;
		end else begin
			b.cnt = have ? 2'd1 : 2'd0;
			b.r0 = rec;
			b.r0.last = have;
		end
		bundle = b;
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_VERSION;
			fcnt_q <= '0;
			shift_q <= '0;
			left_q <= '0;
			idx_q <= '0;
			pos_q <= '0;
			sidx_q <= '0;
			line_q <= '0;
			phase_q <= '0;
			ext_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			step_q <= step_d;
			fcnt_q <= fcnt_d;
			shift_q <= shift_d;
			left_q <= left_d;
			idx_q <= idx_d;
			pos_q <= pos_d;
			sidx_q <= sidx_d;
			line_q <= line_d;
			phase_q <= phase_d;
			ext_q <= ext_d;
		end
	end

endmodule

// ----- rtl/csip_queue.sv -----
// ----------------------------------------------------------------------------
// csip_queue
// Two-entry record bundle queue between the sequencer and the output side.
// ----------------------------------------------------------------------------
module csip_queue import csip_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output logic    full,
	output logic    nonempty,
	output bundle_t head
);

	bundle_t    mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign head = mem_q[rp_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ----- rtl/csip_back.sv -----
// ----------------------------------------------------------------------------
// csip_back
// Output side: sends the one or two records of each queued bundle.
// ----------------------------------------------------------------------------
module csip_back import csip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_nonempty,
	input  bundle_t     q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  record_kind,
	output logic [63:0] record_value,
	output logic [31:0] record_aux,
	output logic        extended_opcode,
	output logic [1:0]  parse_status,
	output logic        run_last
);

	logic sel_q;
	rec_t cur;
	logic take;

	assign cur = sel_q ? q_head.r1 : q_head.r0;
	assign out_valid = q_nonempty;
	assign take = q_nonempty && !out_stall;
	assign q_pop = take && (sel_q || q_head.cnt == 2'd1);

	assign record_kind = cur.kind;
	assign record_value = cur.value;
	assign record_aux = cur.aux;
	assign extended_opcode = cur.ext;
	assign parse_status = cur.status;
	assign run_last = cur.last;

	// Record select within the head bundle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sel_q <= 1'b0;
		else if (take) sel_q <= q_pop ? 1'b0 : 1'b1;
	end

endmodule

// ----- rtl/compiled_script_image_parser.sv -----
// ----------------------------------------------------------------------------
// compiled_script_image_parser
// Byte-serial parser of a compiled-script image into typed records.
// ----------------------------------------------------------------------------
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | data_byte, end_of_data
// out     | out_valid | out_stall | record_kind .. run_last
//
// One byte is taken per cycle while in_stall is low; each byte yields zero,
// one or two records. Records leave one per cycle while out_stall is low.
// A two-bundle queue decouples the sequencer from the output.
// in_stall is high only while that queue is full.
// Reset clears the sequencer to expect a version word and empties the queue.
module compiled_script_image_parser import csip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  record_kind,
	output logic [63:0] record_value,
	output logic [31:0] record_aux,
	output logic        extended_opcode,
	output logic [1:0]  parse_status,
	output logic        run_last
);

	bundle_t fb;
	bundle_t head;
	logic    full;
	logic    nonempty;
	logic    pop;
	logic    push;

	assign in_stall = full;
	assign push = in_valid && !full && (fb.cnt != 2'd0);

	// Front part.
	csip_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .end_of_data(end_of_data), .bundle(fb)
	);

	// Queue.
	csip_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(fb), .pop(pop),
		.full(full), .nonempty(nonempty), .head(head)
	);

	// Back part.
	csip_back u_back (
		.clk(clk), .arst_n(arst_n), .q_nonempty(nonempty), .q_head(head),
		.q_pop(pop), .out_valid(out_valid), .out_stall(out_stall),
		.record_kind(record_kind), .record_value(record_value),
		.record_aux(record_aux), .extended_opcode(extended_opcode),
		.parse_status(parse_status), .run_last(run_last)
	);

`ifndef SYNTHESIS
	// A done record always closes the run of its byte.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind == RK_DONE |-> run_last)
		else $error("done record without run_last");

	// Status is only nonzero on a done record.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && record_kind != RK_DONE |-> parse_status == PS_OK)
		else $error("status on non-done record");

	// A full queue means pending output.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("queue full with no output");
`endif

endmodule
